/* design/ifs_pkg.sv */
`timescale 1ns / 1ps

package ifs_pkg;

  // field width limit and counter widths
  localparam int MAX_FIELD_WIDTH = 512;
  localparam int CNT_W           = 10;
  localparam int CFG_W           = 10;
  localparam int CFG_IDX_W       = 2;

  // depth of the queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_KIND  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DEST  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SKIP  = 2'd3;

  // conversion kinds
  localparam logic [2:0] KIND_DEC  = 3'd0;
  localparam logic [2:0] KIND_AUTO = 3'd1;
  localparam logic [2:0] KIND_OCT  = 3'd2;
  localparam logic [2:0] KIND_UDEC = 3'd3;
  localparam logic [2:0] KIND_HEX  = 3'd4;
  localparam logic [2:0] KIND_BIN  = 3'd5;

  // destination sizes
  localparam logic [1:0] DEST_8  = 2'd0;
  localparam logic [1:0] DEST_16 = 2'd1;
  localparam logic [1:0] DEST_32 = 2'd2;
  localparam logic [1:0] DEST_64 = 2'd3;

  // bases
  localparam logic [4:0] BASE_2  = 5'd2;
  localparam logic [4:0] BASE_8  = 5'd8;
  localparam logic [4:0] BASE_10 = 5'd10;
  localparam logic [4:0] BASE_16 = 5'd16;

  // digit code for a character that is no digit at all
  localparam logic [4:0] NO_DIGIT = 5'd16;

  // reset value of the width register
  localparam logic [CFG_W-1:0] WIDTH_RESET = 10'd512;

  typedef struct packed {
    logic [7:0] ch;
    logic       end_of_input;
  } in_item_t;

  typedef struct packed {
    logic [63:0]      value;
    logic             valid_res;
    logic             char_consumed;
    logic [CNT_W-1:0] chars_used;
    logic             overflowed;
    logic [4:0]       base_used;
  } out_item_t;

  // classified character as it travels through the queue
  typedef struct packed {
    logic       eoi;
    logic       space;
    logic       plus;
    logic       minus;
    logic       zero;
    logic       ex;
    logic [4:0] digit;
  } cls_t;

  typedef struct packed {
    logic [2:0]       kind;
    logic [CFG_W-1:0] max_width;
    logic [1:0]       dest;
    logic             skip;
  } cfg_t;

endpackage

/* design/ifs_front.sv */
`timescale 1ns / 1ps

module ifs_front (
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  ifs_pkg::in_item_t in_data_i,
  input  logic             full_i,
  output logic             push_o,
  output ifs_pkg::cls_t    cls_o
);
  import ifs_pkg::*;

  logic [7:0] c;

  assign c = in_data_i.ch;

  // hold the source off while the queue is full
  assign in_stall_o = full_i;
  assign push_o     = in_valid_i & ~full_i;

  // character classes
  always_comb begin
    cls_o.eoi   = in_data_i.end_of_input;
    cls_o.space = (c == 8'd32) || ((c >= 8'd9) && (c <= 8'd13));
    cls_o.plus  = (c == 8'h2b);
    cls_o.minus = (c == 8'h2d);
    cls_o.zero  = (c == 8'h30);
    cls_o.ex    = (c == 8'h78) || (c == 8'h58);
    if ((c >= 8'h30) && (c <= 8'h39)) begin
      cls_o.digit = 5'(c - 8'h30);
    end else if ((c >= 8'h61) && (c <= 8'h66)) begin
      cls_o.digit = 5'(c - 8'h57);
    end else if ((c >= 8'h41) && (c <= 8'h46)) begin
      cls_o.digit = 5'(c - 8'h37);
    end else begin
      cls_o.digit = NO_DIGIT;
    end
  end

endmodule

/* design/ifs_queue.sv */
`timescale 1ns / 1ps

module ifs_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  ifs_pkg::cls_t wdata_i,
  input  logic          pop_i,
  output ifs_pkg::cls_t rdata_o,
  output logic          valid_o,
  output logic          full_o
);
  import ifs_pkg::*;

  cls_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] count_q, count_d;

  assign valid_o = (count_q != '0);
  assign full_o  = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign rdata_o = mem_q[rd_ptr_q];

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> count_q != '0)
    else $error("pop from empty queue");

endmodule

/* design/ifs_back.sv */
`timescale 1ns / 1ps

module ifs_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ifs_pkg::cfg_t      cfg_i,
  input  logic               q_valid_i,
  input  ifs_pkg::cls_t      q_data_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output ifs_pkg::out_item_t out_data_o
);
  import ifs_pkg::*;

  typedef enum logic [2:0] {
    PH_START,
    PH_SIGNED,
    PH_ZERO,
    PH_HEXPFX,
    PH_DIGITS
  } phase_e;

  // raw result held in the output register, finished on the way out
  typedef struct packed {
    logic [63:0]      mag;
    logic             sat;
    logic             neg;
    logic             ok;
    logic             cons;
    logic [CNT_W-1:0] taken;
    logic [4:0]       base;
  } raw_t;

  function automatic logic [4:0] kind_base(input logic [2:0] k);
    logic [4:0] b;
    case (k)
      KIND_OCT: b = BASE_8;
      KIND_HEX: b = BASE_16;
      KIND_BIN: b = BASE_2;
      default:  b = BASE_10;
    endcase
    return b;
  endfunction

  phase_e           phase_q, ph_v;
  logic [CNT_W-1:0] rem_q, rem_v;
  logic [63:0]      mag_q, mag_v;
  logic             neg_q, neg_v;
  logic             sat_q, sat_v;
  logic [4:0]       base_q, base_v;
  logic [CNT_W-1:0] taken_q, taken_v;
  logic             dseen_q, dseen_v;
  logic             out_valid_q;
  raw_t             res_q;

  logic [2:0]       ek;
  logic             ek_auto;
  logic [CNT_W-1:0] rem_init;
  logic [CNT_W-1:0] rem_cur;
  logic [CNT_W-1:0] rem_dec;
  logic             take_done;
  logic             emit_v, ok_v, cons_v;
  logic             do_ns, do_dig;
  logic [67:0]      prod;
  logic [67:0]      acc;
  logic             adv;

  // effective kind, unknown codes act as signed decimal
  assign ek      = (cfg_i.kind > KIND_BIN) ? KIND_DEC : cfg_i.kind;
  assign ek_auto = (ek == KIND_AUTO);

  // width latched at field start, clamped to the field limit
  assign rem_init = (32'(cfg_i.max_width) > MAX_FIELD_WIDTH) ? CNT_W'(MAX_FIELD_WIDTH)
                                                             : cfg_i.max_width;
  assign rem_cur   = (phase_q == PH_START) ? rem_init : rem_q;
  assign rem_dec   = (rem_cur != '0) ? rem_cur - 1'b1 : '0;
  assign take_done = (rem_dec == '0);

  // one character step
  always_comb begin
    ph_v    = phase_q;
    rem_v   = rem_q;
    mag_v   = mag_q;
    neg_v   = neg_q;
    sat_v   = sat_q;
    base_v  = (phase_q == PH_START) ? kind_base(ek) : base_q;
    taken_v = taken_q;
    dseen_v = dseen_q;
    emit_v  = 1'b0;
    ok_v    = 1'b0;
    cons_v  = 1'b0;
    do_ns   = 1'b0;
    do_dig  = 1'b0;
    prod    = '0;
    acc     = '0;

    if (q_data_i.eoi) begin
      emit_v = 1'b1;
      ok_v   = dseen_q;
    end else begin
      case (phase_q)
        PH_START: begin
          if (cfg_i.skip && q_data_i.space) begin
            // leading whitespace, nothing taken
          end else if (rem_init == '0) begin
            emit_v = 1'b1;
          end else if (q_data_i.plus || q_data_i.minus) begin
            neg_v   = q_data_i.minus;
            ph_v    = PH_SIGNED;
            taken_v = taken_q + 1'b1;
            rem_v   = rem_dec;
            if (take_done) begin
              emit_v = 1'b1;
              cons_v = 1'b1;
            end
          end else begin
            do_ns = 1'b1;
          end
        end
        PH_SIGNED: begin
          do_ns = 1'b1;
        end
        PH_ZERO: begin
          if (q_data_i.ex) begin
            base_v  = BASE_16;
            dseen_v = 1'b0;
            ph_v    = PH_HEXPFX;
            taken_v = taken_q + 1'b1;
            rem_v   = rem_dec;
            if (take_done) begin
              emit_v = 1'b1;
              cons_v = 1'b1;
            end
          end else begin
            if (ek_auto) begin
              base_v = BASE_8;
            end
            do_dig = 1'b1;
          end
        end
        default: begin
          do_dig = 1'b1;
        end
      endcase
    end

    // start of the number proper, after an optional sign
    if (do_ns) begin
      if ((ek_auto || (ek == KIND_HEX)) && q_data_i.zero) begin
        dseen_v = 1'b1;
        ph_v    = PH_ZERO;
        taken_v = taken_q + 1'b1;
        rem_v   = rem_dec;
        if (take_done) begin
          if (ek_auto) begin
            base_v = BASE_8;
          end
          emit_v = 1'b1;
          ok_v   = 1'b1;
          cons_v = 1'b1;
        end
      end else begin
        if (ek_auto) begin
          base_v = BASE_10;
        end
        do_dig = 1'b1;
      end
    end

    // digit accumulate: shift-add by the base, carry out means saturation
    case (base_v)
      BASE_2:  prod = {4'd0, mag_q} << 1;
      BASE_8:  prod = {4'd0, mag_q} << 3;
      BASE_16: prod = {4'd0, mag_q} << 4;
      default: prod = ({4'd0, mag_q} << 3) + ({4'd0, mag_q} << 1);
    endcase
    acc = prod + 68'(q_data_i.digit);

    if (do_dig) begin
      if (q_data_i.digit >= base_v) begin
        emit_v = 1'b1;
        ok_v   = dseen_v;
      end else begin
        if (!sat_q) begin
          if (acc[67:64] != 4'd0) begin
            sat_v = 1'b1;
          end else begin
            mag_v = acc[63:0];
          end
        end
        dseen_v = 1'b1;
        ph_v    = PH_DIGITS;
        taken_v = taken_q + 1'b1;
        rem_v   = rem_dec;
        if (take_done) begin
          emit_v = 1'b1;
          ok_v   = 1'b1;
          cons_v = 1'b1;
        end
      end
    end
  end

  // a step that gives a result waits for room in the output register
  assign adv   = q_valid_i && (!emit_v || !out_valid_q || !out_stall_i);
  assign pop_o = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_START;
      rem_q       <= '0;
      mag_q       <= '0;
      neg_q       <= 1'b0;
      sat_q       <= 1'b0;
      base_q      <= BASE_10;
      taken_q     <= '0;
      dseen_q     <= 1'b0;
      out_valid_q <= 1'b0;
      res_q       <= '0;
    end else begin
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (adv) begin
        if (emit_v) begin
          out_valid_q <= 1'b1;
          res_q.mag   <= mag_v;
          res_q.sat   <= sat_v;
          res_q.neg   <= neg_v;
          res_q.ok    <= ok_v;
          res_q.cons  <= cons_v;
          res_q.taken <= taken_v;
          res_q.base  <= base_v;
          phase_q     <= PH_START;
          rem_q       <= '0;
          mag_q       <= '0;
          neg_q       <= 1'b0;
          sat_q       <= 1'b0;
          base_q      <= kind_base(ek);
          taken_q     <= '0;
          dseen_q     <= 1'b0;
        end else begin
          phase_q <= ph_v;
          rem_q   <= rem_v;
          mag_q   <= mag_v;
          neg_q   <= neg_v;
          sat_q   <= sat_v;
          base_q  <= base_v;
          taken_q <= taken_v;
          dseen_q <= dseen_v;
        end
      end
    end
  end

  // signed or unsigned saturation, negation and truncation to the destination
  logic [63:0] val;
  logic        ovf;
  logic [63:0] neg_mag;

  assign neg_mag = 64'd0 - res_q.mag;

  always_comb begin
    val = '0;
    ovf = 1'b0;
    if (res_q.ok) begin
      if (ek == KIND_DEC || ek_auto) begin
        if (res_q.neg) begin
          if (res_q.sat || (res_q.mag > 64'h8000_0000_0000_0000)) begin
            val = 64'h8000_0000_0000_0000;
            ovf = 1'b1;
          end else begin
            val = neg_mag;
          end
        end else begin
          if (res_q.sat || res_q.mag[63]) begin
            val = 64'h7fff_ffff_ffff_ffff;
            ovf = 1'b1;
          end else begin
            val = res_q.mag;
          end
        end
      end else begin
        if (res_q.sat) begin
          val = '1;
          ovf = 1'b1;
        end else begin
          val = res_q.neg ? neg_mag : res_q.mag;
        end
      end
      case (cfg_i.dest)
        DEST_8:  val = {56'd0, val[7:0]};
        DEST_16: val = {48'd0, val[15:0]};
        DEST_32: val = {32'd0, val[31:0]};
        default: val = val;
      endcase
    end
  end

  assign out_valid_o              = out_valid_q;
  assign out_data_o.value         = val;
  assign out_data_o.valid_res     = res_q.ok;
  assign out_data_o.char_consumed = res_q.cons;
  assign out_data_o.chars_used    = res_q.taken;
  assign out_data_o.overflowed    = ovf;
  assign out_data_o.base_used     = res_q.base;

  a_start_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_START |-> taken_q == '0 && !dseen_q && mag_q == '0)
    else $error("field state not cleared at field start");

  a_digits_seen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_DIGITS |-> dseen_q && taken_q != '0)
    else $error("digit phase without a digit taken");

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_stall_i |=> out_valid_q && $stable(res_q))
    else $error("stalled result word lost or changed");

endmodule

/* design/integer_field_scanner_core.sv */
`timescale 1ns / 1ps

// a terminating word is first stored in the queue, then the back-end step writes its result
// word into the output register; throughput: one character word per cycle unless a result
// waits on a stalled output, and the back-end step is one shift-add per cycle
// a two-entry queue decouples the classifier from the back end, an output register holds results
// reset: asynchronous active low; registers return to kind 0, width 512, size 32, skip on,
// the scanner waits for a new field and queue and output are empty
module integer_field_scanner_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [ifs_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [ifs_pkg::CFG_W-1:0]      cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  ifs_pkg::in_item_t              in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output ifs_pkg::out_item_t             out_data_o
);
  import ifs_pkg::*;

  cfg_t cfg_q;
  logic push;
  cls_t push_cls;
  logic q_full;
  logic q_valid;
  cls_t q_data;
  logic pop;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.kind      <= KIND_DEC;
      cfg_q.max_width <= WIDTH_RESET;
      cfg_q.dest      <= DEST_32;
      cfg_q.skip      <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_KIND:  cfg_q.kind      <= cfg_wdata_i[2:0];
        REG_WIDTH: cfg_q.max_width <= cfg_wdata_i;
        REG_DEST:  cfg_q.dest      <= cfg_wdata_i[1:0];
        REG_SKIP:  cfg_q.skip      <= cfg_wdata_i[0];
        default:   cfg_q           <= cfg_q;
      endcase
    end
  end

  ifs_front u_front (
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .full_i     (q_full),
    .push_o     (push),
    .cls_o      (push_cls)
  );

  ifs_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (push_cls),
    .pop_i   (pop),
    .rdata_o (q_data),
    .valid_o (q_valid),
    .full_o  (q_full)
  );

  ifs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_valid_i   (q_valid),
    .q_data_i    (q_data),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

/* tb/integer_field_scanner_core_test.sv */
`timescale 1ns / 1ps

module integer_field_scanner_core_test;
  import ifs_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 8;
  localparam int PHASE_COUNT   = 14;
  localparam int PHASE_WORDS   = 65;
  localparam int LONG_PHASE    = 5;
  localparam int LONG_DIGITS   = 515;
  localparam int REPORT_LIMIT  = 10;

  // kind code outside the defined range, scanned as signed decimal
  localparam logic [2:0] KIND_SPARE = 3'd6;

  typedef enum int {
    SCAN_START,
    SCAN_SIGNED,
    SCAN_ZERO,
    SCAN_HEX_PREFIX,
    SCAN_DIGITS
  } scan_state_e;

  // field predictor and queue of expected result words
  class field_scoreboard;
    logic [2:0]       kind;
    logic [CFG_W-1:0] max_w;
    logic [1:0]       dest;
    logic             skip;
    scan_state_e      state;
    int unsigned      left, taken, base;
    logic [63:0]      mag;
    bit               neg, sat, seen;
    out_item_t        expected_q[$];
    int unsigned      errors;

    function new();
      kind   = KIND_DEC;
      max_w  = WIDTH_RESET;
      dest   = DEST_32;
      skip   = 1'b1;
      errors = 0;
      restart();
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      case (idx)
        REG_KIND:  kind = data[2:0];
        REG_WIDTH: max_w = data;
        REG_DEST:  dest = data[1:0];
        REG_SKIP:  skip = data[0];
        default: ;
      endcase
    endfunction

    function logic [2:0] eff_kind();
      return (kind > KIND_BIN) ? KIND_DEC : kind;
    endfunction

    function int unsigned radix_of(logic [2:0] k);
      case (k)
        KIND_OCT: return BASE_8;
        KIND_HEX: return BASE_16;
        KIND_BIN: return BASE_2;
        default:  return BASE_10;
      endcase
    endfunction

    function bit is_blank(logic [7:0] c);
      return c == " " || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function int unsigned digit_of(logic [7:0] c);
      if (c >= "0" && c <= "9") return c - "0";
      if (c >= "a" && c <= "f") return c - "a" + 10;
      if (c >= "A" && c <= "F") return c - "A" + 10;
      return NO_DIGIT;
    endfunction

    function void restart();
      state = SCAN_START;
      left  = 0;
      mag   = '0;
      neg   = 1'b0;
      sat   = 1'b0;
      taken = 0;
      seen  = 1'b0;
      base  = radix_of(eff_kind());
    endfunction

    // close the field: saturate, negate and cut to the destination size
    function void push_result(bit ok, bit consumed);
      out_item_t   r;
      logic [63:0] v;
      bit          ovf;
      logic [2:0]  k;
      v   = '0;
      ovf = 1'b0;
      k   = eff_kind();
      if (ok) begin
        if (k == KIND_DEC || k == KIND_AUTO) begin
          if (neg) begin
            if (sat || mag > 64'h8000_0000_0000_0000) begin
              v   = 64'h8000_0000_0000_0000;
              ovf = 1'b1;
            end else begin
              v = 64'd0 - mag;
            end
          end else if (sat || mag > 64'h7FFF_FFFF_FFFF_FFFF) begin
            v   = 64'h7FFF_FFFF_FFFF_FFFF;
            ovf = 1'b1;
          end else begin
            v = mag;
          end
        end else if (sat) begin
          v   = '1;
          ovf = 1'b1;
        end else begin
          v = neg ? 64'd0 - mag : mag;
        end
        case (dest)
          DEST_8:  v = v & 64'hFF;
          DEST_16: v = v & 64'hFFFF;
          DEST_32: v = v & 64'hFFFF_FFFF;
          default: ;
        endcase
      end
      r.value         = v;
      r.valid_res     = ok;
      r.char_consumed = consumed;
      r.chars_used    = CNT_W'(taken);
      r.overflowed    = ovf;
      r.base_used     = 5'(base);
      expected_q.push_back(r);
      restart();
    endfunction

    // count one character into the field, true once the width is used up
    function bit take_char();
      taken++;
      if (left > 0) left--;
      return left == 0;
    endfunction

    function void accumulate(logic [7:0] c);
      int unsigned d;
      d = digit_of(c);
      if (d >= base) begin
        push_result(seen, 1'b0);
        return;
      end
      if (!sat) begin
        if (mag > (64'hFFFF_FFFF_FFFF_FFFF - 64'(d)) / 64'(base)) sat = 1'b1;
        else mag = mag * 64'(base) + 64'(d);
      end
      seen  = 1'b1;
      state = SCAN_DIGITS;
      if (take_char()) push_result(1'b1, 1'b1);
    endfunction

    // first character after the sign: a leading zero may open a prefix
    function void begin_number(logic [7:0] c);
      logic [2:0] k;
      k = eff_kind();
      if ((k == KIND_AUTO || k == KIND_HEX) && c == "0") begin
        seen  = 1'b1;
        state = SCAN_ZERO;
        if (take_char()) begin
          if (k == KIND_AUTO) base = BASE_8;
          push_result(1'b1, 1'b1);
        end
        return;
      end
      if (k == KIND_AUTO) base = BASE_10;
      accumulate(c);
    endfunction

    function void note_input(in_item_t w);
      if (state == SCAN_START) base = radix_of(eff_kind());
      if (w.end_of_input) begin
        push_result(seen, 1'b0);
        return;
      end
      case (state)
        SCAN_START: begin
          if (skip && is_blank(w.ch)) return;
          left = (max_w > MAX_FIELD_WIDTH) ? MAX_FIELD_WIDTH : max_w;
          if (left == 0) begin
            push_result(1'b0, 1'b0);
            return;
          end
          if (w.ch == "+" || w.ch == "-") begin
            neg   = (w.ch == "-");
            state = SCAN_SIGNED;
            if (take_char()) push_result(1'b0, 1'b1);
            return;
          end
          begin_number(w.ch);
        end
        SCAN_SIGNED: begin_number(w.ch);
        SCAN_ZERO: begin
          if (w.ch == "x" || w.ch == "X") begin
            base  = BASE_16;
            seen  = 1'b0;
            state = SCAN_HEX_PREFIX;
            if (take_char()) push_result(1'b0, 1'b1);
          end else begin
            if (eff_kind() == KIND_AUTO) base = BASE_8;
            accumulate(w.ch);
          end
        end
        default: accumulate(w.ch);
      endcase
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= REPORT_LIMIT)
          $display("result word with nothing expected: value %h valid %0b used %0d",
                   got.value, got.valid_res, got.chars_used);
        return;
      end
      want = expected_q.pop_front();
      if (got.value !== want.value || got.valid_res !== want.valid_res ||
          got.char_consumed !== want.char_consumed || got.chars_used !== want.chars_used ||
          got.overflowed !== want.overflowed || got.base_used !== want.base_used) begin
        errors++;
        if (errors <= REPORT_LIMIT) begin
          $display("mismatch expected: value %h valid %0b consumed %0b used %0d ovf %0b base %0d",
                   want.value, want.valid_res, want.char_consumed, want.chars_used,
                   want.overflowed, want.base_used);
          $display("         actual:   value %h valid %0b consumed %0b used %0d ovf %0b base %0d",
                   got.value, got.valid_res, got.char_consumed, got.chars_used,
                   got.overflowed, got.base_used);
        end
      end
    endfunction
  endclass

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx   = REG_KIND;
  logic [CFG_W-1:0]     cfg_wdata = '0;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  in_item_t             in_data   = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_item_t            out_data;

  int unsigned     in_idle_pct = 0;
  int unsigned     stall_pct   = 0;
  int unsigned     words_sent  = 0;
  field_scoreboard sb          = new();

  integer_field_scanner_core u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  always #5 clk = ~clk;

  // watchdog
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("DONE: errors detected");
    $finish;
  end

  // receiver back-pressure
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // words moved on either channel at this edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_input(in_data);
      if (out_valid && !out_stall) sb.check_result(out_data);
    end
  end

  function automatic logic [7:0] blank_char();
    int unsigned r;
    r = $urandom_range(5);
    return (r == 5) ? 8'd32 : 8'(9 + r);
  endfunction

  function automatic logic [7:0] digit_char(input int unsigned radix);
    int unsigned v;
    v = $urandom_range(radix - 1);
    if (v < 10) return 8'("0" + v);
    return 8'(($urandom_range(1) ? "A" : "a") + v - 10);
  endfunction

  // offer one word, with random idle cycles ahead of it
  task automatic send_word(input in_item_t w);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    words_sent++;
  endtask

  task automatic send_char(input logic [7:0] c);
    in_item_t w;
    w.ch           = c;
    w.end_of_input = 1'b0;
    send_word(w);
  endtask

  task automatic send_end(input logic [7:0] c);
    in_item_t w;
    w.ch           = c;
    w.end_of_input = 1'b1;
    send_word(w);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  // drain all results, then let the classifier queue empty out
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    sb.write_reg(idx, data);
    @(posedge clk);
  endtask

  task automatic set_config(input logic [2:0] k, input logic [CFG_W-1:0] width,
                            input logic [1:0] d, input logic s);
    settle();
    write_reg(REG_KIND, CFG_W'(k));
    write_reg(REG_WIDTH, width);
    write_reg(REG_DEST, CFG_W'(d));
    write_reg(REG_SKIP, CFG_W'(s));
    cfg_we <= 1'b0;
  endtask

  // one field: mostly well formed with random content, sometimes plain noise
  task automatic send_field();
    logic [2:0]  k;
    int unsigned radix, n_digits;
    in_item_t    w;
    k     = sb.eff_kind();
    radix = sb.radix_of(k);
    if ($urandom_range(99) < 12) begin
      repeat ($urandom_range(1, 6)) begin
        w.ch           = 8'($urandom);
        w.end_of_input = ($urandom_range(9) == 0);
        send_word(w);
      end
      return;
    end
    repeat ($urandom_range(3)) send_char(blank_char());
    case ($urandom_range(2))
      1: send_char("+");
      2: send_char("-");
      default: ;
    endcase
    if ((k == KIND_HEX || k == KIND_AUTO) && $urandom_range(2) == 0) begin
      send_char("0");
      send_char($urandom_range(1) ? "x" : "X");
      radix = BASE_16;
    end else if (k == KIND_AUTO && $urandom_range(3) == 0) begin
      send_char("0");
      radix = BASE_8;
    end
    if ($urandom_range(15) == 0) n_digits = 0;
    else if ($urandom_range(7) == 0) n_digits = $urandom_range(18, 30);
    else n_digits = $urandom_range(1, 8);
    repeat (n_digits) send_char(digit_char(radix));
    // terminator: end marker, arbitrary byte, blank or a possibly foreign digit
    case ($urandom_range(3))
      0: send_end(8'($urandom));
      1: send_char(8'($urandom));
      2: send_char(blank_char());
      default: send_char(digit_char(BASE_16));
    endcase
  endtask

  initial begin
    int unsigned      first;
    logic [CFG_W-1:0] width;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: signed decimal, full width, 32-bit result, blanks skipped
    send_text("\t-9x");
    send_char("+");
    send_char(8'hFF);
    // hex prefix with no digit after it, blank taken as field start
    set_config(KIND_HEX, 10'd512, DEST_64, 1'b0);
    send_text("0x");
    send_char(8'h00);
    send_char(" ");
    // auto base: hex, then octal
    set_config(KIND_AUTO, 10'd512, DEST_16, 1'b1);
    send_text("0X1f");
    send_end(8'hFF);
    send_text("017 ");
    // unsigned negation with the width used up
    set_config(KIND_UDEC, 10'd2, DEST_8, 1'b1);
    send_text("-5");
    // zero width
    set_config(KIND_UDEC, 10'd0, DEST_8, 1'b1);
    send_text("7");
    // unknown kind and a width beyond the limit
    set_config(KIND_SPARE, 10'd1023, DEST_64, 1'b1);
    send_text("-3");
    send_end(8'h00);

    // random phases over all kinds, widths, sizes and idling patterns
    for (int p = 0; p < PHASE_COUNT; p++) begin
      case (p)
        3:       width = 10'd0;
        5:       width = 10'd1023;
        8:       width = 10'd1;
        11:      width = 10'd512;
        default: width = CFG_W'($urandom_range(1, 24));
      endcase
      set_config(3'(p), width, 2'((p + p / 8) % 4), (p % 3) != 0);
      case (p % 4)
        0: begin
          in_idle_pct = 0;
          stall_pct   = 0;
        end
        1: begin
          in_idle_pct = 69;
          stall_pct   = 0;
        end
        2: begin
          in_idle_pct = 0;
          stall_pct   = 69;
        end
        default: begin
          in_idle_pct = 14;
          stall_pct   = 14;
        end
      endcase
      first = words_sent;
      // one field long enough to run into the clamped width
      if (p == LONG_PHASE) begin
        repeat (LONG_DIGITS) send_char(digit_char(sb.radix_of(sb.eff_kind())));
        send_end(8'($urandom));
      end
      while (words_sent - first < PHASE_WORDS) send_field();
    end

    settle();
    if (sb.errors == 0 && sb.pending() == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
